/* rtl/hfa_pkg.sv */
// hfa_pkg: shared codes and field widths for the hole fit allocator.
// No dependencies; imported by hole_fit_allocator_unit.
package hfa_pkg;

  localparam int TARGET_W = 4;
  localparam int AMOUNT_W = 16;
  localparam int HOLE_W   = 4;
  localparam int REMAIN_W = 16;
  localparam int COUNT_W  = 5;
  localparam int POLICY_W = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // register index as taken from paddr[2]
  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_HOLE_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] HOLE_COUNT_RST = 5'd16;

endpackage

/* rtl/hole_fit_allocator_unit.sv */
// hole_fit_allocator_unit: hole table with first/next/best/worst fit allocation.
// Depends on hfa_pkg (codes, field widths).
//
// Usage: words enter on the s_ stream group, results leave on the m_ group.
// s_tuser is func: a load word writes target_hole's size, an allocate word
// asks for amount and is served from one hole by the configured policy.
// Every input word yields exactly one result word (ok, chosen_hole, remaining).
// A load moves through ST_FINISH, where its result enters the output register
// and m_tvalid rises. An allocate scans the holes in use through one
// registered table read port and one shared compare unit, one hole per cycle,
// then writes back in ST_UPDATE before ST_FINISH. s_tready is high only while
// the unit is idle, so no new word is taken until the last one has left
// ST_FINISH; an allocate is bound by the serial scan through the single read port.
// The result sits in an output register; if m_tready is low the next word
// is still taken, and its result waits until the output register is free.
// Reset (rst, synchronous) empties all holes, clears the next fit pointer,
// sets policy to first fit and hole_count to 16. The APB port sets policy
// (offset 0) and hole_count (offset 4) and must only be written while idle.
module hole_fit_allocator_unit #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // [3:0] target_hole, [19:4] amount
  input  logic [0:0]                  s_tuser,   // [0] func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // [3:0] chosen_hole, [19:4] remaining
  output logic [0:0]                  m_tuser,   // [0] ok
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hfa_pkg::CFG_AW-1:0]  paddr,
  input  logic [hfa_pkg::CFG_DW-1:0]  pwdata,
  output logic [hfa_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import hfa_pkg::*;

  localparam int IDXW = $clog2(NUM_HOLES);
  localparam int CNTW = $clog2(NUM_HOLES + 1);
  localparam int CMPW = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t                state;
  policy_t               policy;
  logic [COUNT_W-1:0]    hole_count;
  logic [IDXW-1:0]       np;

  logic [SIZE_BITS-1:0]  mem [NUM_HOLES];
  logic [NUM_HOLES-1:0]  valid;
  logic [SIZE_BITS-1:0]  rd_data;
  logic                  rd_vld;

  logic                  iss_on;
  logic [IDXW-1:0]       iss_pos;
  logic [CNTW-1:0]       iss_k;
  logic [CNTW-1:0]       cnt;
  logic                  cmp_on;
  logic                  cmp_last;
  logic [IDXW-1:0]       cmp_pos;

  logic [AMOUNT_W-1:0]   req;
  logic                  found;
  logic [IDXW-1:0]       pick;
  logic [SIZE_BITS-1:0]  pick_sz;

  logic                  res_ok;
  logic [HOLE_W-1:0]     res_hole;
  logic [REMAIN_W-1:0]   res_rem;

  logic                  in_func;
  logic [TARGET_W-1:0]   in_target;
  logic [AMOUNT_W-1:0]   in_amount;
  logic                  in_fire;
  logic                  tgt_ok;
  logic [SIZE_BITS-1:0]  load_sz;
  logic [CNTW-1:0]       cnt_eff;
  logic [IDXW-1:0]       start_pos;
  logic [IDXW-1:0]       pos_step;
  logic [SIZE_BITS-1:0]  sz;
  logic                  fits;
  logic                  take;
  logic [SIZE_BITS-1:0]  new_sz;
  logic                  wr_en;
  logic [IDXW-1:0]       wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;
  logic                  cfg_wr;

  assign in_func   = s_tuser[0];
  assign in_target = s_tdata[3:0];
  assign in_amount = s_tdata[19:4];
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign tgt_ok    = (32'(in_target) < NUM_HOLES);
  assign load_sz   = SIZE_BITS'(in_amount);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == REG_POLICY) begin
      prdata = CFG_DW'(policy);
    end else begin
      prdata = CFG_DW'(hole_count);
    end
  end

  always_comb begin
    if (hole_count == '0) begin
      cnt_eff = CNTW'(1);
    end else if (32'(hole_count) > NUM_HOLES) begin
      cnt_eff = CNTW'(NUM_HOLES);
    end else begin
      cnt_eff = CNTW'(hole_count);
    end
  end

  assign start_pos = (policy == POL_NEXT && 32'(np) < 32'(cnt_eff)) ? np : '0;
  assign pos_step  = (32'(iss_pos) + 1 == 32'(cnt)) ? '0 : IDXW'(32'(iss_pos) + 1);

  // shared compare unit
  assign sz   = rd_vld ? rd_data : '0;
  assign fits = (CMPW'(sz) >= CMPW'(req));
  always_comb begin
    case (policy)
      POL_FIRST, POL_NEXT: take = fits && !found;
      POL_BEST:            take = fits && (!found || sz < pick_sz);
      POL_WORST:           take = fits && (!found || sz > pick_sz);
      default:             take = 1'b0;
    endcase
  end

  assign new_sz = SIZE_BITS'(CMPW'(pick_sz) - CMPW'(req));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IDXW'(in_target);
    wr_data = load_sz;
    if (state == ST_IDLE) begin
      wr_en = in_fire && (in_func == FUNC_LOAD) && tgt_ok;
    end else if (state == ST_UPDATE) begin
      wr_en   = found;
      wr_addr = pick;
      wr_data = new_sz;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[iss_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[iss_pos];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      policy     <= POL_FIRST;
      hole_count <= HOLE_COUNT_RST;
      np         <= '0;
      iss_on     <= 1'b0;
      cmp_on     <= 1'b0;
      cmp_last   <= 1'b0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_POLICY) begin
          policy <= policy_t'(pwdata[POLICY_W-1:0]);
        end else begin
          hole_count <= pwdata[COUNT_W-1:0];
        end
      end

      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            req   <= in_amount;
            found <= 1'b0;
            if (in_func == FUNC_LOAD) begin
              res_ok   <= tgt_ok;
              res_hole <= tgt_ok ? in_target : '0;
              res_rem  <= tgt_ok ? REMAIN_W'(load_sz) : '0;
              state    <= ST_FINISH;
            end else begin
              cnt     <= cnt_eff;
              iss_pos <= start_pos;
              iss_k   <= '0;
              iss_on  <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_on   <= iss_on;
          cmp_pos  <= iss_pos;
          cmp_last <= iss_on && (iss_k == CNTW'(cnt - CNTW'(1)));
          if (iss_on) begin
            iss_pos <= pos_step;
            iss_k   <= CNTW'(iss_k + CNTW'(1));
            if (iss_k == CNTW'(cnt - CNTW'(1))) begin
              iss_on <= 1'b0;
            end
          end
          if (cmp_on) begin
            if (take) begin
              found   <= 1'b1;
              pick    <= cmp_pos;
              pick_sz <= sz;
            end
            if (cmp_last) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          res_ok   <= found;
          res_hole <= found ? HOLE_W'(pick) : '0;
          res_rem  <= found ? REMAIN_W'(new_sz) : '0;
          if (found && policy == POL_NEXT) begin
            np <= pick;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {4'b0, res_rem, res_hole};
            m_tuser <= res_ok;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
